/* hdl/bbts_pkg.sv */
// bbts_pkg: shared types, tag tables and command/status structs for the markup stripper
// used by bbts_ctrl, bbts_dpath, bbcode_tag_stripper_core and bbts_checker
`timescale 1ns / 1ps

package bbts_pkg;

    localparam int CHAR_BITS = 16;
    localparam int NUM_TAGS  = 8;
    localparam int MAX_TAG   = 8;
    localparam int TAG_W     = 3;
    localparam int TAG_POS_W = 3;

    localparam logic [7:0] CH_LBRACK   = 8'h5B;
    localparam logic [7:0] CH_RBRACK   = 8'h5D;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] CH_NUL      = 8'h00;

    // tag order sets match priority
    localparam logic [7:0] TAG_TEXT [NUM_TAGS][MAX_TAG] = '{
        '{"[", "b", "]", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"[", "i", "]", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"[", "/", "b", "]", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"[", "/", "i", "]", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"[", "c", "o", "l", "o", "r", CH_NUL, CH_NUL},
        '{"[", "/", "c", "o", "l", "o", "r", "]"},
        '{"[", "s", "i", "z", "e", CH_NUL, CH_NUL, CH_NUL},
        '{"[", "/", "s", "i", "z", "e", "]", CH_NUL}
    };

    localparam logic [3:0] TAG_LEN [NUM_TAGS] = '{
        4'd3, 4'd3, 4'd4, 4'd4, 4'd6, 4'd8, 4'd5, 4'd7
    };

    // open color and size tags drop up to the next closing bracket
    localparam logic [NUM_TAGS-1:0] TAG_SKIP = 8'b0101_0000;

    typedef struct packed {
        logic [CHAR_BITS-1:0] in_char;
        logic                 in_last;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] out_char;
        logic                 out_valid;
        logic                 out_end;
    } out_word_t;

    typedef enum logic [1:0] {
        LD_HOLD,
        LD_CHAR,
        LD_BARE
    } load_kind_t;

    typedef struct packed {
        logic       accept;
        logic       load;
        load_kind_t kind;
        logic       step;
        logic       commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic dec_flush;
        logic dec_emit;
        logic dec_bare;
        logic item_emit;
        logic flush_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

/* hdl/bbts_ctrl.sv */
// bbts_ctrl: sequencer for accept, flush of held words, character and end marker
// depends on bbts_pkg for command and status structs
`timescale 1ns / 1ps

module bbts_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bbts_pkg::ctrl_sts_t sts,
    output bbts_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH,
        S_CHAR,
        S_BARE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    assign s_ready = s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = bbts_pkg::LD_BARE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.accept = 1'b1;
                    if (sts.dec_flush) begin
                        state_next = S_FLUSH;
                    end else if (sts.dec_emit) begin
                        state_next = S_CHAR;
                    end else if (sts.dec_bare) begin
                        state_next = S_BARE;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FLUSH: begin
                if (sts.out_free) begin
                    cmd.load = 1'b1;
                    cmd.kind = bbts_pkg::LD_HOLD;
                    cmd.step = 1'b1;
                    if (sts.flush_last) begin
                        if (sts.item_emit) begin
                            state_next = S_CHAR;
                        end else begin
                            cmd.commit = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_CHAR: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.kind   = bbts_pkg::LD_CHAR;
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BARE: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.kind   = bbts_pkg::LD_BARE;
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DONE: begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
        end
    end

endmodule

/* hdl/bbts_dpath.sv */
// bbts_dpath: hold buffer, tag matcher, strip state and output register
// depends on bbts_pkg for tag tables, payload types and command/status structs
`timescale 1ns / 1ps

module bbts_dpath #(
    parameter int HOLD_DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bbts_pkg::in_word_t   s_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  bbts_pkg::ctrl_cmd_t  cmd,
    output bbts_pkg::ctrl_sts_t  sts,
    input  logic                 m_ready,
    output logic                 m_valid,
    output bbts_pkg::out_word_t  m_data
);

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = $clog2(HOLD_DEPTH);
    localparam int CB    = bbts_pkg::CHAR_BITS;
    localparam int NT    = bbts_pkg::NUM_TAGS;

    // committed state
    logic                 enable_reg;
    logic [CB-1:0]        hold_reg [HOLD_DEPTH];
    logic [CNT_W-1:0]     count_reg;
    logic                 skip_reg;
    logic [NT-1:0]        alive_reg;

    // current item and its pending update
    logic [CB-1:0]        item_char_reg;
    logic                 item_last_reg;
    logic                 item_emit_reg;
    logic [CNT_W-1:0]     nflush_reg;
    logic [CNT_W-1:0]     cnt_new_reg;
    logic                 skip_new_reg;
    logic [NT-1:0]        alive_new_reg;
    logic                 wr_en_reg;
    logic [IDX_W-1:0]     wr_idx_reg;
    logic [IDX_W-1:0]     idx_reg;

    bbts_pkg::out_word_t  out_reg, out_next;
    logic                 m_valid_reg, m_valid_next;

    // decision for the word on s_data
    logic [CB-1:0]              fchar;
    logic [NT-1:0]              hit;
    logic [bbts_pkg::TAG_W-1:0] sel;
    logic                       complete;
    logic [CNT_W-1:0]           dec_nflush;
    logic                       dec_emit;
    logic [CNT_W-1:0]           dec_cnt;
    logic                       dec_skip;
    logic [NT-1:0]              dec_alive;
    logic                       dec_wr;
    logic [IDX_W-1:0]           dec_wr_idx;
    logic                       flush_last;

    always_comb begin
        if (s_data.in_char >= CB'(bbts_pkg::CH_UPPER_A) &&
            s_data.in_char <= CB'(bbts_pkg::CH_UPPER_Z)) begin
            fchar = s_data.in_char + CB'(bbts_pkg::CASE_OFFSET);
        end else begin
            fchar = s_data.in_char;
        end
    end

    always_comb begin
        for (int t = 0; t < NT; t++) begin
            hit[t] = alive_reg[t] &&
                     (count_reg < CNT_W'(bbts_pkg::TAG_LEN[t])) &&
                     (fchar == CB'(bbts_pkg::TAG_TEXT[t][count_reg[bbts_pkg::TAG_POS_W-1:0]]));
        end
    end

    always_comb begin
        sel = '0;
        for (int t = NT - 1; t >= 0; t--) begin
            if (hit[t]) begin
                sel = bbts_pkg::TAG_W'(t);
            end
        end
        complete = (CNT_W'(count_reg + CNT_W'(1)) == CNT_W'(bbts_pkg::TAG_LEN[sel]));
    end

    always_comb begin
        dec_nflush = '0;
        dec_emit   = 1'b0;
        dec_cnt    = '0;
        dec_skip   = 1'b0;
        dec_alive  = alive_reg;
        dec_wr     = 1'b0;
        dec_wr_idx = '0;
        if (!enable_reg) begin
            dec_nflush = count_reg;
            dec_emit   = 1'b1;
        end else if (skip_reg) begin
            dec_skip = (s_data.in_char != CB'(bbts_pkg::CH_RBRACK));
        end else if (count_reg != '0 && count_reg < CNT_W'(HOLD_DEPTH) && (|hit)) begin
            if (complete) begin
                dec_skip = bbts_pkg::TAG_SKIP[sel];
            end else begin
                dec_cnt    = CNT_W'(count_reg + CNT_W'(1));
                dec_wr     = 1'b1;
                dec_wr_idx = count_reg[IDX_W-1:0];
                dec_alive  = hit;
            end
        end else begin
            dec_nflush = count_reg;
            if (s_data.in_char == CB'(bbts_pkg::CH_LBRACK)) begin
                dec_cnt    = CNT_W'(1);
                dec_wr     = 1'b1;
                dec_wr_idx = '0;
                dec_alive  = '1;
            end else begin
                dec_emit = 1'b1;
            end
        end
        // end of text flushes anything that would be held
        if (s_data.in_last) begin
            if (dec_wr) begin
                dec_nflush = count_reg;
                dec_emit   = 1'b1;
            end
            dec_wr   = 1'b0;
            dec_cnt  = '0;
            dec_skip = 1'b0;
        end
    end

    assign flush_last = (CNT_W'(CNT_W'(idx_reg) + CNT_W'(1)) == nflush_reg);

    always_comb begin
        sts.dec_flush  = (dec_nflush != '0);
        sts.dec_emit   = dec_emit;
        sts.dec_bare   = s_data.in_last && (dec_nflush == '0) && !dec_emit;
        sts.item_emit  = item_emit_reg;
        sts.flush_last = flush_last;
        sts.out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        case (cmd.kind)
            bbts_pkg::LD_HOLD: begin
                out_next.out_char  = hold_reg[idx_reg];
                out_next.out_valid = 1'b1;
                out_next.out_end   = item_last_reg && flush_last && !item_emit_reg;
            end
            bbts_pkg::LD_CHAR: begin
                out_next.out_char  = item_char_reg;
                out_next.out_valid = 1'b1;
                out_next.out_end   = item_last_reg;
            end
            bbts_pkg::LD_BARE: begin
                out_next.out_char  = '0;
                out_next.out_valid = 1'b0;
                out_next.out_end   = 1'b1;
            end
            default: begin
                out_next.out_char  = '0;
                out_next.out_valid = 1'b0;
                out_next.out_end   = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b1;
            count_reg   <= '0;
            skip_reg    <= 1'b0;
            alive_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                enable_reg <= cfg_data;
            end
            if (cmd.commit) begin
                count_reg <= cnt_new_reg;
                skip_reg  <= skip_new_reg;
                alive_reg <= alive_new_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_char_reg <= s_data.in_char;
            item_last_reg <= s_data.in_last;
            item_emit_reg <= dec_emit;
            nflush_reg    <= dec_nflush;
            cnt_new_reg   <= dec_cnt;
            skip_new_reg  <= dec_skip;
            alive_new_reg <= dec_alive;
            wr_en_reg     <= dec_wr;
            wr_idx_reg    <= dec_wr_idx;
            idx_reg       <= '0;
        end else if (cmd.step) begin
            idx_reg <= IDX_W'(idx_reg + IDX_W'(1));
        end
        if (cmd.commit && wr_en_reg) begin
            hold_reg[wr_idx_reg] <= item_char_reg;
        end
        if (cmd.load) begin
            out_reg <= out_next;
        end
    end

endmodule

/* hdl/bbcode_tag_stripper_core.sv */
// bbcode_tag_stripper_core: top level of the markup tag stripper
// depends on bbts_pkg, bbts_ctrl and bbts_dpath
// the word is accepted in the idle state; its results are loaded into the output register
// from the flush, character or bare state; a new word is taken only when the last is done;
// flushing n held words (up to 7) gives one result per cycle, plus output stalls
// reset: synchronous active-low, clears hold count, skip flag and output valid, enable to 1
`timescale 1ns / 1ps

module bbcode_tag_stripper_core #(
    parameter int HOLD_DEPTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bbts_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bbts_pkg::out_word_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    bbts_pkg::ctrl_cmd_t cmd;
    bbts_pkg::ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    bbts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bbts_dpath #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

/* hdl/bbts_checker.sv */
// bbts_checker: port-level assertions for bbcode_tag_stripper_core, bound to the top level
// depends on bbts_pkg for payload types
`timescale 1ns / 1ps

module bbts_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input bbts_pkg::in_word_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input bbts_pkg::out_word_t m_data,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic                cfg_data
);

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after an accept");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // bare marker is always the end of text with a zero character
    a_bare_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_valid |-> m_data.out_end && (m_data.out_char == '0))
        else $error("bare result without end flag or with nonzero char");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind bbcode_tag_stripper_core bbts_checker u_bbts_checker (.*);
